// ===== rtl/box_blur_5x5_rgb_unit_macros.svh =====
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb_unit_macros.svh
// Assertion macros used by the checker of the 5x5 box blur.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_5X5_RGB_UNIT_MACROS_SVH
`define BOX_BLUR_5X5_RGB_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define BB5_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked during reset
`define BB5_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// state in the cycle after reset is applied
`define BB5_ASSERT_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bb5_pkg.sv =====
// ----------------------------------------------------------------------------
// bb5_pkg
// Types and constants of the 5x5 RGB box blur.
// ----------------------------------------------------------------------------
package bb5_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MIN_SIZE   = 5;

    localparam int CFG_BITS   = 12;
    localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
    localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

    localparam int LINES      = 4;
    localparam int BANK_BITS  = $clog2(LINES);
    localparam int WIN        = 5;
    localparam int CHANNELS   = 3;
    localparam int CH_BITS    = 8;

    localparam int RESET_WIDTH  = 1280;
    localparam int RESET_HEIGHT = 720;

    localparam int CS_BITS    = $clog2(WIN * 255 + 1);
    localparam int SUM_BITS   = $clog2(WIN * WIN * 255 + 1);
    // x / 25 == (x * DIV_MUL) >> DIV_SHIFT for every x below 2**DIV_SHIFT / 3
    localparam int DIV_SHIFT  = 17;
    localparam int DIV_MUL    = ((1 << DIV_SHIFT) + 24) / (WIN * WIN);
    localparam int MUL_BITS   = $clog2(DIV_MUL + 1);
    localparam int PROD_BITS  = SUM_BITS + MUL_BITS;

    typedef enum logic [0:0] {
        CFG_LINE_WIDTH   = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // element 0 red, 1 green, 2 blue
    typedef logic [CHANNELS-1:0][CH_BITS-1:0] t_rgb;
    typedef logic [CS_BITS-1:0]   t_csum;
    typedef t_csum [CHANNELS-1:0] t_csum_rgb;
    typedef logic [SUM_BITS-1:0]  t_sum;
    typedef t_sum [CHANNELS-1:0]  t_sum_rgb;
    typedef logic [PROD_BITS-1:0] t_prod;
    typedef t_prod [CHANNELS-1:0] t_prod_rgb;

    typedef struct packed {
        logic border;
        logic pre_frame;
    } t_flags;

    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic               frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [CH_BITS-1:0] out_red;
        logic [CH_BITS-1:0] out_green;
        logic [CH_BITS-1:0] out_blue;
        logic               border_zero;
        logic               before_frame;
    } t_pix_out;

endpackage

// ===== rtl/box_blur_5x5_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_5x5_rgb_unit
// Streaming 5x5 box filter on RGB pixels in raster order.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready / i_in_data): one pixel per request,
// frame_start marks row 0, column 0. Output channel (o_out_valid /
// i_out_ready / o_out_data): one result per request, for the pixel two rows
// and two columns behind the input, in request order.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): line_width and
// frame_height, clamped to 5..MAX on write; write only while idle.
// Throughput: one pixel per cycle, sustained while the output is not stalled;
// all four line banks are read and one bank is written at the incoming column.
// Path: a result passes the input stage, column sum, window sum, reciprocal
// multiply and output registers in that order.
// Stall: each stage holds when the next is full; up to five requests sit in
// flight and bubbles close up while the output waits.
// Reset: position, window column sums and sizes (1280 x 720) are set, the
// pipeline is emptied; the line store is not cleared and its stale contents
// only reach border or before-frame results.
// ----------------------------------------------------------------------------
module box_blur_5x5_rgb_unit import bb5_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  t_cfg_idx            i_cfg_index,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_pix_in             i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_pix_out            o_out_data
);

    logic [W_BITS-1:0]   r_w;
    logic [H_BITS-1:0]   r_h;
    logic [W_BITS-1:0]   n_w;
    logic [H_BITS-1:0]   n_h;

    logic [COL_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0] r_row, n_row;

    logic                r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_o_valid;
    logic                rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;
    logic                acc, ld_b, ld_c, ld_d, ld_o;

    logic [COL_BITS-1:0] col;
    logic [ROW_BITS-1:0] row;
    logic [W_BITS:0]     ccol;
    logic [ROW_BITS-1:0] crow;
    t_flags              n_a_flags;
    t_rgb                pix;

    t_rgb [LINES-1:0]    rd_line;
    t_rgb                r_a_pix;
    t_flags              r_a_flags, r_b_flags, r_c_flags, r_d_flags;
    t_csum_rgb           n_b_col, r_b_col;
    t_csum_rgb [WIN-2:0] r_win;
    t_sum_rgb            n_c_sum, r_c_sum;
    t_prod_rgb           r_d_prod;
    t_pix_out            n_o_data, r_o_data;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data < CFG_BITS'(MIN_SIZE)) begin
            n_w = W_BITS'(MIN_SIZE);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            n_w = W_BITS'(MAX_WIDTH);
        end else begin
            n_w = W_BITS'(i_cfg_data);
        end
        if (i_cfg_data < CFG_BITS'(MIN_SIZE)) begin
            n_h = H_BITS'(MIN_SIZE);
        end else if (32'(i_cfg_data) > MAX_HEIGHT) begin
            n_h = H_BITS'(MAX_HEIGHT);
        end else begin
            n_h = H_BITS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= W_BITS'(RESET_WIDTH);
            r_h <= H_BITS'(RESET_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_w <= n_w;
                CFG_FRAME_HEIGHT: r_h <= n_h;
                default: ;
            endcase
        end
    end

    // ---------------- handshake chain ----------------
    assign rdy_o = !r_o_valid || i_out_ready;
    assign rdy_d = !r_d_valid || rdy_o;
    assign rdy_c = !r_c_valid || rdy_d;
    assign rdy_b = !r_b_valid || rdy_c;
    assign rdy_a = !r_a_valid || rdy_b;

    assign o_in_ready = rdy_a;
    assign acc  = i_in_valid && rdy_a;
    assign ld_b = r_a_valid && rdy_b;
    assign ld_c = r_b_valid && rdy_c;
    assign ld_d = r_c_valid && rdy_d;
    assign ld_o = r_d_valid && rdy_o;

    // ---------------- position, center and flags ----------------
    assign pix = {i_in_data.blue, i_in_data.green, i_in_data.red};

    always_comb begin
        col = i_in_data.frame_start ? '0 : r_col;
        row = i_in_data.frame_start ? '0 : r_row;

        n_a_flags.pre_frame = (row < ROW_BITS'(2)) ||
                              ((row == ROW_BITS'(2)) && (col < COL_BITS'(2)));

        if (col >= COL_BITS'(2)) begin
            ccol = (W_BITS+1)'(col) - (W_BITS+1)'(2);
            crow = row - ROW_BITS'(2);
        end else begin
            ccol = (W_BITS+1)'(col) + (W_BITS+1)'(r_w) - (W_BITS+1)'(2);
            crow = row - ROW_BITS'(3);
        end

        n_a_flags.border = !n_a_flags.pre_frame &&
                           ((ccol < (W_BITS+1)'(2)) ||
                            (ccol + (W_BITS+1)'(2) >= (W_BITS+1)'(r_w)) ||
                            (crow < ROW_BITS'(2)) ||
                            ((H_BITS+1)'(crow) + (H_BITS+1)'(2) >= (H_BITS+1)'(r_h)));

        if (W_BITS'(col) + W_BITS'(1) >= r_w) begin
            n_col = '0;
            n_row = (H_BITS'(row) + H_BITS'(1) >= r_h) ? '0 : row + ROW_BITS'(1);
        end else begin
            n_col = col + COL_BITS'(1);
            n_row = row;
        end
    end

    bb5_line_store u_line_store (
        .i_clk     (i_clk),
        .i_en      (acc),
        .i_wr_bank (row[BANK_BITS-1:0]),
        .i_addr    (col),
        .i_wdata   (pix),
        .o_rdata   (rd_line)
    );

    // ---------------- datapath ----------------
    // new window column: four stored lines plus the incoming pixel
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_b_col[ch] = CS_BITS'(r_a_pix[ch]);
            for (int l = 0; l < LINES; l++) begin
                n_b_col[ch] = n_b_col[ch] + CS_BITS'(rd_line[l][ch]);
            end
        end
    end

    // window sum: four kept columns plus the new one
    always_comb begin
        for (int ch = 0; ch < CHANNELS; ch++) begin
            n_c_sum[ch] = SUM_BITS'(r_b_col[ch]);
            for (int k = 0; k < WIN - 1; k++) begin
                n_c_sum[ch] = n_c_sum[ch] + SUM_BITS'(r_win[k][ch]);
            end
        end
    end

    always_comb begin
        n_o_data = '0;
        n_o_data.border_zero  = r_d_flags.border;
        n_o_data.before_frame = r_d_flags.pre_frame;
        if (!r_d_flags.border && !r_d_flags.pre_frame) begin
            n_o_data.out_red   = r_d_prod[0][DIV_SHIFT +: CH_BITS];
            n_o_data.out_green = r_d_prod[1][DIV_SHIFT +: CH_BITS];
            n_o_data.out_blue  = r_d_prod[2][DIV_SHIFT +: CH_BITS];
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_win     <= '0;
        end else begin
            if (acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (rdy_a) r_a_valid <= i_in_valid;
            if (rdy_b) r_b_valid <= r_a_valid;
            if (rdy_c) r_c_valid <= r_b_valid;
            if (rdy_d) r_d_valid <= r_c_valid;
            if (rdy_o) r_o_valid <= r_d_valid;
            if (ld_c) begin
                for (int k = 0; k < WIN - 2; k++) begin
                    r_win[k] <= r_win[k+1];
                end
                r_win[WIN-2] <= r_b_col;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_pix   <= pix;
            r_a_flags <= n_a_flags;
        end
        if (ld_b) begin
            r_b_col   <= n_b_col;
            r_b_flags <= r_a_flags;
        end
        if (ld_c) begin
            r_c_sum   <= n_c_sum;
            r_c_flags <= r_b_flags;
        end
        if (ld_d) begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_d_prod[ch] <= PROD_BITS'(r_c_sum[ch]) * PROD_BITS'(DIV_MUL);
            end
            r_d_flags <= r_c_flags;
        end
        if (ld_o) begin
            r_o_data  <= n_o_data;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

// ===== rtl/bb5_line_store.sv =====
// ----------------------------------------------------------------------------
// bb5_line_store
// Four line banks; all read at one column, one bank written there.
// ----------------------------------------------------------------------------
module bb5_line_store import bb5_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [BANK_BITS-1:0] i_wr_bank,
    input  logic [COL_BITS-1:0]  i_addr,
    input  t_rgb                 i_wdata,
    output t_rgb [LINES-1:0]     o_rdata
);

    for (genvar b = 0; b < LINES; b++) begin : g_bank
        t_rgb r_mem [MAX_WIDTH];
        t_rgb r_rdata;

        // read-first: the bank being written returns the line four rows up
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rdata <= r_mem[i_addr];
                if (i_wr_bank == BANK_BITS'(b)) begin
                    r_mem[i_addr] <= i_wdata;
                end
            end
        end

        assign o_rdata[b] = r_rdata;
    end

endmodule

// ===== rtl/bb5_checker.sv =====
// ----------------------------------------------------------------------------
// bb5_checker
// Port-level checks of the 5x5 box blur, bound to the top level.
// ----------------------------------------------------------------------------
`include "box_blur_5x5_rgb_unit_macros.svh"

module bb5_checker import bb5_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_ready,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_pix_out i_out_data
);

    `BB5_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result changed while stalled")

    `BB5_ASSERT_IMP(a_flags_excl, i_clk, i_rst_n, i_out_valid, !(i_out_data.border_zero && i_out_data.before_frame), "border and before-frame both set")

    `BB5_ASSERT_IMP(a_flag_zero, i_clk, i_rst_n, i_out_valid && (i_out_data.border_zero || i_out_data.before_frame), (i_out_data.out_red == '0) && (i_out_data.out_green == '0) && (i_out_data.out_blue == '0), "flagged result carries pixel data")

    `BB5_ASSERT_RST(a_reset_empty, i_clk, i_rst_n, !i_out_valid && i_in_ready, "pipeline not empty after reset")

endmodule

bind box_blur_5x5_rgb_unit bb5_checker u_bb5_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
